// ===== sv/rrtt_pkg.sv =====
package rrtt_pkg;

   localparam int TASK_SLOTS = 16;
   localparam int CORE_COUNT = 4;

   localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CORE_IDX_W = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
   localparam int TOT_W      = $clog2(TASK_SLOTS + 1);
   localparam int MEM_DEPTH  = CORE_COUNT * TASK_SLOTS;
   localparam int MEM_ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   typedef enum logic [2:0] {
      CMD_FORK  = 3'd0,
      CMD_TICK  = 3'd1,
      CMD_YIELD = 3'd2,
      CMD_EXIT  = 3'd3,
      CMD_BLOCK = 3'd4,
      CMD_ALLOW = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_EMPTY  = 2'd0,
      ST_READY  = 2'd1,
      ST_RUN    = 2'd2,
      ST_ZOMBIE = 2'd3
   } slot_state_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [1:0] core;
   } req_type;

   typedef struct packed {
      logic       status;
      logic       switched;
      logic [3:0] prev_slot;
      logic [3:0] cur_slot;
      logic [3:0] new_slot;
      logic [4:0] live_count;
   } rsp_type;

   typedef struct packed {
      slot_state_type    state;
      logic              pblock;
      logic [SLOT_W-1:0] next;
   } entry_type;

   typedef struct packed {
      logic [CORE_IDX_W-1:0] core;
      logic [SLOT_W-1:0]     slot;
   } mem_addr_type;

   typedef struct packed {
      logic         en;
      mem_addr_type addr;
      entry_type    data;
   } mem_wr_type;

   typedef struct packed {
      logic    busy;
      logic    done;
      rsp_type rsp;
   } ctrl_out_type;

endpackage

// ===== sv/rrtt_slot_mem.sv =====
module rrtt_slot_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  rrtt_pkg::mem_addr_type rd_addr,
   output rrtt_pkg::entry_type    rd_data,
   input  rrtt_pkg::mem_wr_type   wr
);

   function automatic logic [rrtt_pkg::MEM_ADDR_W-1:0] flat_addr(rrtt_pkg::mem_addr_type a);
      return rrtt_pkg::MEM_ADDR_W'(int'(a.core) * rrtt_pkg::TASK_SLOTS + int'(a.slot));
   endfunction

   rrtt_pkg::entry_type mem [rrtt_pkg::MEM_DEPTH];
   logic                valid_ff [rrtt_pkg::MEM_DEPTH];
   rrtt_pkg::entry_type rd_data_ff;
   rrtt_pkg::entry_type reset_entry;
   logic [rrtt_pkg::MEM_ADDR_W-1:0] ra;
   logic [rrtt_pkg::MEM_ADDR_W-1:0] wa;

   assign ra = flat_addr(rd_addr);
   assign wa = flat_addr(wr.addr);

   // untouched entry: slot zero runs in a ring of one, others are empty
   always_comb begin
      reset_entry.state  = (rd_addr.slot == '0) ? rrtt_pkg::ST_RUN : rrtt_pkg::ST_EMPTY;
      reset_entry.pblock = 1'b0;
      reset_entry.next   = '0;
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wa] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rrtt_pkg::MEM_DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (wr.en) begin
         valid_ff[wa] <= 1'b1;
      end
   end

   // forward a same-cycle write to the read port
   always_ff @(posedge clock) begin
      if (wr.en && (wa == ra)) begin
         rd_data_ff <= wr.data;
      end else if (valid_ff[ra]) begin
         rd_data_ff <= mem[ra];
      end else begin
         rd_data_ff <= reset_entry;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rrtt_ctrl.sv =====
module rrtt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  rrtt_pkg::req_type       req,
   output rrtt_pkg::ctrl_out_type  ctrl_out,
   output rrtt_pkg::mem_addr_type  mem_rd,
   input  rrtt_pkg::entry_type     mem_rd_data,
   output rrtt_pkg::mem_wr_type    mem_wr
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_CMD    = 9'b000000010,
      S_FSCAN  = 9'b000000100,
      S_FCUR   = 9'b000001000,
      S_FLINK  = 9'b000010000,
      S_WALK   = 9'b000100000,
      S_WBCUR  = 9'b001000000,
      S_WBT    = 9'b010000000,
      S_DONE   = 9'b100000000
   } fsm_type;

   localparam logic [rrtt_pkg::SLOT_W-1:0] LAST_SLOT =
      rrtt_pkg::SLOT_W'(rrtt_pkg::TASK_SLOTS - 1);
   localparam logic [rrtt_pkg::TOT_W-1:0] TOT_ONE  = rrtt_pkg::TOT_W'(1);
   localparam logic [rrtt_pkg::TOT_W-1:0] TOT_FULL = rrtt_pkg::TOT_W'(rrtt_pkg::TASK_SLOTS);

   fsm_type                             state_ff, state_in;
   rrtt_pkg::cmd_type                   cmd_ff, cmd_in;
   logic [rrtt_pkg::CORE_IDX_W-1:0]     core_ff, core_in;
   logic                                bad_ff, bad_in;
   logic [rrtt_pkg::SLOT_W-1:0]         cur_ff, cur_in;
   logic [rrtt_pkg::SLOT_W-1:0]         chk_ff, chk_in;
   logic [rrtt_pkg::SLOT_W-1:0]         t_ff, t_in;
   logic [rrtt_pkg::SLOT_W-1:0]         n_ff, n_in;
   logic [rrtt_pkg::SLOT_W-1:0]         p_ff, p_in;
   rrtt_pkg::entry_type                 ce_ff, ce_in;
   rrtt_pkg::entry_type                 te_ff, te_in;
   logic                                first_ff, first_in;
   logic                                found_ff, found_in;
   logic                                status_ff, status_in;
   logic [rrtt_pkg::SLOT_W-1:0]         running_ff [rrtt_pkg::CORE_COUNT];
   logic [rrtt_pkg::SLOT_W-1:0]         running_in [rrtt_pkg::CORE_COUNT];
   logic [rrtt_pkg::TOT_W-1:0]          total_ff [rrtt_pkg::CORE_COUNT];
   logic [rrtt_pkg::TOT_W-1:0]          total_in [rrtt_pkg::CORE_COUNT];

   logic [rrtt_pkg::CORE_IDX_W-1:0]     req_idx;
   logic                                req_bad;
   logic [rrtt_pkg::TOT_W-1:0]          tot;
   logic [rrtt_pkg::TOT_W-1:0]          tot_dec;
   rrtt_pkg::entry_type                 walk_e;
   logic [rrtt_pkg::SLOT_W-1:0]         run_cur;

   assign req_bad = (int'(req.core) >= rrtt_pkg::CORE_COUNT);
   assign req_idx = req_bad ? '0 : rrtt_pkg::CORE_IDX_W'(req.core);
   assign tot     = total_ff[core_ff];
   assign tot_dec = (tot == '0) ? '0 : tot - TOT_ONE;
   assign walk_e  = first_ff ? ce_ff : mem_rd_data;
   assign run_cur = running_ff[core_ff];

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      core_in    = core_ff;
      bad_in     = bad_ff;
      cur_in     = cur_ff;
      chk_in     = chk_ff;
      t_in       = t_ff;
      n_in       = n_ff;
      p_in       = p_ff;
      ce_in      = ce_ff;
      te_in      = te_ff;
      first_in   = first_ff;
      found_in   = found_ff;
      status_in  = status_ff;
      running_in = running_ff;
      total_in   = total_ff;
      mem_rd.core = core_ff;
      mem_rd.slot = cur_ff;
      mem_wr      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in    = rrtt_pkg::cmd_type'(req.cmd);
               core_in   = req_idx;
               bad_in    = req_bad;
               cur_in    = running_ff[req_idx];
               p_in      = '0;
               status_in = 1'b0;
               found_in  = 1'b0;
               mem_rd.core = req_idx;
               mem_rd.slot = running_ff[req_idx];
               if (req_bad) begin
                  state_in = S_DONE;
               end else if (rrtt_pkg::cmd_type'(req.cmd) == rrtt_pkg::CMD_FORK) begin
                  if (total_ff[req_idx] >= TOT_FULL) begin
                     status_in = 1'b1;
                     state_in  = S_DONE;
                  end else begin
                     mem_rd.slot = rrtt_pkg::SLOT_W'(1);
                     chk_in      = rrtt_pkg::SLOT_W'(1);
                     state_in    = S_FSCAN;
                  end
               end else begin
                  state_in = S_CMD;
               end
            end
         end

         S_CMD: begin
            ce_in    = mem_rd_data;
            first_in = 1'b1;
            n_in     = '0;
            t_in     = cur_ff;
            state_in = S_DONE;
            unique case (cmd_ff)
               rrtt_pkg::CMD_TICK: begin
                  if (!mem_rd_data.pblock && (tot != TOT_ONE)) begin
                     ce_in.pblock = 1'b1;
                     state_in     = S_WALK;
                  end
               end
               rrtt_pkg::CMD_YIELD: begin
                  if (tot != TOT_ONE) begin
                     ce_in.pblock = 1'b1;
                     state_in     = S_WALK;
                  end
               end
               rrtt_pkg::CMD_EXIT: begin
                  ce_in.state       = rrtt_pkg::ST_ZOMBIE;
                  ce_in.pblock      = 1'b1;
                  total_in[core_ff] = tot_dec;
                  if (tot_dec != TOT_ONE) begin
                     state_in = S_WALK;
                  end else begin
                     mem_wr.en        = 1'b1;
                     mem_wr.addr.core = core_ff;
                     mem_wr.addr.slot = cur_ff;
                     mem_wr.data      = ce_in;
                  end
               end
               rrtt_pkg::CMD_BLOCK, rrtt_pkg::CMD_ALLOW: begin
                  ce_in.pblock     = (cmd_ff == rrtt_pkg::CMD_BLOCK);
                  mem_wr.en        = 1'b1;
                  mem_wr.addr.core = core_ff;
                  mem_wr.addr.slot = cur_ff;
                  mem_wr.data      = ce_in;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_WALK: begin
            first_in = 1'b0;
            if (walk_e.state == rrtt_pkg::ST_READY) begin
               found_in = 1'b1;
               te_in    = walk_e;
               state_in = S_WBCUR;
            end else if ((walk_e.next == cur_ff) || (n_ff == LAST_SLOT)) begin
               found_in = 1'b0;
               state_in = S_WBCUR;
            end else begin
               mem_rd.slot = walk_e.next;
               t_in        = walk_e.next;
               n_in        = n_ff + rrtt_pkg::SLOT_W'(1);
            end
         end

         S_WBCUR: begin
            mem_wr.en        = 1'b1;
            mem_wr.addr.core = core_ff;
            mem_wr.addr.slot = cur_ff;
            mem_wr.data      = ce_ff;
            if (found_ff) begin
               if (ce_ff.state != rrtt_pkg::ST_ZOMBIE) begin
                  mem_wr.data.state = rrtt_pkg::ST_READY;
               end
               state_in = S_WBT;
            end else begin
               mem_wr.data.pblock = 1'b0;
               state_in           = S_DONE;
            end
         end

         S_WBT: begin
            mem_wr.en          = 1'b1;
            mem_wr.addr.core   = core_ff;
            mem_wr.addr.slot   = t_ff;
            mem_wr.data.state  = rrtt_pkg::ST_RUN;
            mem_wr.data.pblock = 1'b0;
            mem_wr.data.next   = te_ff.next;
            running_in[core_ff] = t_ff;
            state_in            = S_DONE;
         end

         S_FSCAN: begin
            if ((mem_rd_data.state == rrtt_pkg::ST_EMPTY) ||
                (mem_rd_data.state == rrtt_pkg::ST_ZOMBIE)) begin
               p_in = chk_ff;
               if (tot == '0) begin
                  mem_wr.en          = 1'b1;
                  mem_wr.addr.core   = core_ff;
                  mem_wr.addr.slot   = chk_ff;
                  mem_wr.data.state  = rrtt_pkg::ST_READY;
                  mem_wr.data.pblock = 1'b1;
                  mem_wr.data.next   = chk_ff;
                  running_in[core_ff] = chk_ff;
                  total_in[core_ff]   = TOT_ONE;
                  state_in            = S_DONE;
               end else begin
                  state_in = S_FCUR;
               end
            end else if (chk_ff == LAST_SLOT) begin
               status_in = 1'b1;
               state_in  = S_DONE;
            end else begin
               chk_in      = chk_ff + rrtt_pkg::SLOT_W'(1);
               mem_rd.slot = chk_ff + rrtt_pkg::SLOT_W'(1);
            end
         end

         S_FCUR: begin
            ce_in              = mem_rd_data;
            mem_wr.en          = 1'b1;
            mem_wr.addr.core   = core_ff;
            mem_wr.addr.slot   = p_ff;
            mem_wr.data.state  = rrtt_pkg::ST_READY;
            mem_wr.data.pblock = 1'b1;
            mem_wr.data.next   = mem_rd_data.next;
            state_in           = S_FLINK;
         end

         S_FLINK: begin
            mem_wr.en        = 1'b1;
            mem_wr.addr.core = core_ff;
            mem_wr.addr.slot = cur_ff;
            mem_wr.data      = ce_ff;
            mem_wr.data.next = p_ff;
            // running slot reclaimed as its own successor: ring of one
            if (cur_ff == p_ff) begin
               mem_wr.data.state  = rrtt_pkg::ST_READY;
               mem_wr.data.pblock = 1'b1;
            end
            total_in[core_ff] = tot + TOT_ONE;
            state_in          = S_DONE;
         end

         S_DONE: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         core_ff  <= '0;
         for (int i = 0; i < rrtt_pkg::CORE_COUNT; i++) begin
            running_ff[i] <= '0;
            total_ff[i]   <= TOT_ONE;
         end
      end else begin
         state_ff   <= state_in;
         core_ff    <= core_in;
         running_ff <= running_in;
         total_ff   <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      bad_ff    <= bad_in;
      cur_ff    <= cur_in;
      chk_ff    <= chk_in;
      t_ff      <= t_in;
      n_ff      <= n_in;
      p_ff      <= p_in;
      ce_ff     <= ce_in;
      te_ff     <= te_in;
      first_ff  <= first_in;
      found_ff  <= found_in;
      status_ff <= status_in;
   end

   always_comb begin
      ctrl_out.busy = (state_ff != S_IDLE);
      ctrl_out.done = (state_ff == S_DONE);
      if (bad_ff) begin
         ctrl_out.rsp = '0;
      end else begin
         ctrl_out.rsp.status     = status_ff;
         ctrl_out.rsp.switched   = (run_cur != cur_ff);
         ctrl_out.rsp.prev_slot  = 4'(cur_ff);
         ctrl_out.rsp.cur_slot   = 4'(run_cur);
         ctrl_out.rsp.new_slot   = 4'(p_ff);
         ctrl_out.rsp.live_count = 5'(tot);
      end
   end

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_wr.en)
      else $error("slot memory written while idle");

   a_switch_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WBT) |-> found_ff)
      else $error("switch write-back without a ready slot");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff[core_ff] <= TOT_FULL)
      else $error("live task count above slot count");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && (state_ff == S_IDLE)) |=> (state_ff != S_IDLE))
      else $error("accepted command did not leave idle");

   a_run_stable: assert property (@(posedge clock) disable iff (reset)
      ((state_ff != S_IDLE) && (state_ff != S_WBT) && (state_ff != S_FSCAN))
      |=> $stable(running_ff[core_ff]))
      else $error("running slot changed outside a switch or fork");

endmodule

// ===== sv/round_robin_thread_table.sv =====
// Per-core round-robin thread table.
// Request channel: drive req_data (cmd, core) with start; the transfer happens at
// a rising edge where start is high and busy is low. One command is in flight at
// a time; busy drops in the cycle the result is out, so the next transfer can
// land on the same edge that takes the result.
// Result channel: rsp_data carries one result per command and is valid for
// exactly one cycle while rsp_strobe is high. The receiver cannot stall: it must
// take the result in that cycle.
// Command flow: a fork refused on a full live count, block/allow, unknown commands
// and a schedule skipped on a single live task finish without a loop; a fork scans
// up to 15 slots for a free one, and a switch, or a walk that finds no ready slot,
// visits up to 16 ring slots. Both loops are set by the single read port of the
// slot memory, one slot per cycle.
// Reset: every core restarts with slot 0 running as main in a ring of one and
// a live count of one. Per-entry valid bits in the slot memory clear in the
// reset cycle itself, so no clearing pass follows; start is taken right after.
module round_robin_thread_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rrtt_pkg::req_type req_data,
   output logic              rsp_strobe,
   output rrtt_pkg::rsp_type rsp_data
);

   rrtt_pkg::ctrl_out_type ctrl_out;
   rrtt_pkg::mem_addr_type mem_rd;
   rrtt_pkg::entry_type    mem_rd_data;
   rrtt_pkg::mem_wr_type   mem_wr;

   logic              rsp_strobe_ff;
   rrtt_pkg::rsp_type rsp_ff;

   // sequencer: fork scan, ring walk and write-back of one core's slots
   rrtt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req         (req_data),
      .ctrl_out    (ctrl_out),
      .mem_rd      (mem_rd),
      .mem_rd_data (mem_rd_data),
      .mem_wr      (mem_wr)
   );

   // slot state, preempt-block flag and ring link for every core and slot
   rrtt_slot_mem u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (mem_rd),
      .rd_data (mem_rd_data),
      .wr      (mem_wr)
   );

   // register the finished result and its strobe on the output
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctrl_out.done;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_out.done) begin
         rsp_ff <= ctrl_out.rsp;
      end
   end

   assign busy       = ctrl_out.busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== tb/tb_round_robin_thread_table.sv =====
`timescale 1ns / 100ps

module tb_round_robin_thread_table;
   import rrtt_pkg::*;

   // Command codes outside the defined set; the block must report and leave state alone.
   localparam logic [2:0] CMD_UNDEF_LO = 3'd6;
   localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 2;
   // Slowest event is a switch, with a walk over every slot of the ring.
   localparam int DRAIN_CYCLES  = 30;
   // Cycles without a transfer on either side before the run is declared hung.
   localparam int HANG_LIMIT    = 2000;
   localparam int RANDOM_EVENTS = 1000;
   localparam int PHASE_COUNT   = 4;

   typedef struct {
      logic [2:0] cmd;
      logic [1:0] core;
      int         reps;
      bit         typed;
      rsp_type    typed_rsp;
   } script_row_t;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_strobe;
   rsp_type rsp;

   // Shadow copy of every core's thread table.
   slot_state_type shadow_state [CORE_COUNT][TASK_SLOTS];
   int             shadow_link  [CORE_COUNT][TASK_SLOTS];
   bit             shadow_pblock[CORE_COUNT][TASK_SLOTS];
   int             shadow_running[CORE_COUNT];
   int             shadow_live   [CORE_COUNT];

   rsp_type     pending_rsps[$];
   script_row_t script_rows[$];
   rsp_type     due_rsp;
   int          error_count;
   int          hang_cycles;

   round_robin_thread_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------------------
   // Thread table predictor
   // ---------------------------------------------------------------------------

   // Put every core back to main (slot 0) running alone in its ring.
   function automatic void clear_shadow_tables();
      for (int c = 0; c < CORE_COUNT; c++) begin
         for (int s = 0; s < TASK_SLOTS; s++) begin
            shadow_state[c][s]  = ST_EMPTY;
            shadow_link[c][s]   = 0;
            shadow_pblock[c][s] = 1'b0;
         end
         shadow_state[c][0] = ST_RUN;
         shadow_running[c]  = 0;
         shadow_live[c]     = 1;
      end
   endfunction

   // Walk the ring from the running slot (inclusive) to the first ready slot.
   // A ring that never closes is cut off after one full table of visits.
   function automatic void switch_to_next_ready(int c);
      int  cur;
      int  t;
      bit  found;
      cur   = shadow_running[c];
      t     = cur;
      found = 1'b0;
      // A single live task never gives up the core.
      if (shadow_live[c] == 1)
         return;
      shadow_pblock[c][cur] = 1'b1;
      for (int n = 0; n < TASK_SLOTS; n++) begin
         if (shadow_state[c][t] == ST_READY) begin
            found = 1'b1;
            break;
         end
         t = shadow_link[c][t];
         if (t == cur)
            break;
      end
      if (found) begin
         // A zombie stays a zombie; anything else drops back to ready.
         if (shadow_state[c][cur] != ST_ZOMBIE)
            shadow_state[c][cur] = ST_READY;
         shadow_state[c][t] = ST_RUN;
         shadow_running[c]  = t;
      end
      shadow_pblock[c][shadow_running[c]] = 1'b0;
   endfunction

   // Claim the lowest empty or zombie slot above main; return 0 when refused.
   function automatic int fork_thread(int c);
      int p;
      int cur;
      p = 0;
      if (shadow_live[c] >= TASK_SLOTS)
         return 0;
      for (int i = 1; i < TASK_SLOTS; i++) begin
         if (shadow_state[c][i] == ST_EMPTY || shadow_state[c][i] == ST_ZOMBIE) begin
            p = i;
            break;
         end
      end
      if (p == 0)
         return 0;
      shadow_state[c][p]  = ST_READY;
      shadow_pblock[c][p] = 1'b1;
      if (shadow_live[c] == 0) begin
         // Nothing live: the new thread takes the core in a ring of its own.
         shadow_running[c] = p;
         shadow_link[c][p] = p;
      end else begin
         // Splice in right after the running thread.
         cur                 = shadow_running[c];
         shadow_link[c][p]   = shadow_link[c][cur];
         shadow_link[c][cur] = p;
      end
      shadow_live[c]++;
      return p;
   endfunction

   // Apply one scheduler event to the shadow tables and return the report.
   function automatic rsp_type predict_thread_event(logic [2:0] cmd, logic [1:0] core);
      rsp_type r;
      int      c;
      int      prev;
      int      claimed;
      r       = '0;
      c       = int'(core);
      claimed = 0;
      if (c >= CORE_COUNT)
         return r;
      prev = shadow_running[c];
      case (cmd)
         CMD_FORK: begin
            claimed = fork_thread(c);
            if (claimed == 0)
               r.status = 1'b1;
         end
         CMD_TICK: begin
            if (!shadow_pblock[c][prev])
               switch_to_next_ready(c);
         end
         CMD_YIELD: begin
            switch_to_next_ready(c);
         end
         CMD_EXIT: begin
            shadow_pblock[c][prev] = 1'b1;
            shadow_state[c][prev]  = ST_ZOMBIE;
            if (shadow_live[c] > 0)
               shadow_live[c]--;
            switch_to_next_ready(c);
         end
         CMD_BLOCK: begin
            shadow_pblock[c][prev] = 1'b1;
         end
         CMD_ALLOW: begin
            shadow_pblock[c][prev] = 1'b0;
         end
         default: begin
         end
      endcase
      r.switched   = (shadow_running[c] != prev);
      r.prev_slot  = 4'(prev);
      r.cur_slot   = 4'(shadow_running[c]);
      r.new_slot   = 4'(claimed);
      r.live_count = 5'(shadow_live[c]);
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic rsp_type make_rsp(bit status, bit switched, int prev, int cur,
                                        int claimed, int live);
      rsp_type r;
      r.status     = status;
      r.switched   = switched;
      r.prev_slot  = 4'(prev);
      r.cur_slot   = 4'(cur);
      r.new_slot   = 4'(claimed);
      r.live_count = 5'(live);
      return r;
   endfunction

   task automatic add_row(logic [2:0] cmd, logic [1:0] core, int reps, bit typed,
                          rsp_type typed_rsp);
      script_row_t row;
      row.cmd       = cmd;
      row.core      = core;
      row.reps      = reps;
      row.typed     = typed;
      row.typed_rsp = typed_rsp;
      script_rows.push_back(row);
   endtask

   // Present one event and hold it until the block takes the transfer. The
   // caller decides whether start drops afterwards, so start gets a single
   // nonblocking write per time step.
   task automatic issue_event(logic [2:0] cmd, logic [1:0] core, bit typed,
                              rsp_type typed_rsp);
      req_type r;
      rsp_type p;
      r.cmd  = cmd;
      r.core = core;
      start <= 1'b1;
      req   <= r;
      do @(posedge clock); while (busy);
      // Always advance the shadow tables; a typed row only replaces what is expected.
      p = predict_thread_event(cmd, core);
      pending_rsps.push_back(typed ? typed_rsp : p);
   endtask

   // Drop start for a random stretch; idle_pct is the chance per cycle to stay idle.
   task automatic sender_pause(int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // Mostly well-formed scheduler traffic, with a trickle of undefined codes.
   function automatic logic [2:0] pick_command();
      int roll;
      roll = $urandom_range(99);
      if (roll < 22)      return CMD_FORK;
      else if (roll < 42) return CMD_TICK;
      else if (roll < 62) return CMD_YIELD;
      else if (roll < 80) return CMD_EXIT;
      else if (roll < 88) return CMD_BLOCK;
      else if (roll < 96) return CMD_ALLOW;
      else if (roll < 98) return CMD_UNDEF_LO;
      else                return CMD_UNDEF_HI;
   endfunction

   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                  act_val);
         error_count++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Result checking: the receiver cannot stall, so take every strobe as it comes.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_rsps.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp);
            error_count++;
         end else begin
            due_rsp = pending_rsps.pop_front();
            check_field("status",     due_rsp.status,     rsp.status);
            check_field("switched",   due_rsp.switched,   rsp.switched);
            check_field("prev_slot",  due_rsp.prev_slot,  rsp.prev_slot);
            check_field("cur_slot",   due_rsp.cur_slot,   rsp.cur_slot);
            check_field("new_slot",   due_rsp.new_slot,   rsp.new_slot);
            check_field("live_count", due_rsp.live_count, rsp.live_count);
         end
      end
   end

   // Hang detection: count cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         hang_cycles <= 0;
      end else begin
         hang_cycles <= hang_cycles + 1;
         if (hang_cycles >= HANG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      int         idle_pct[PHASE_COUNT];
      int         focus_core;
      logic [1:0] core;

      // Phases: no idling, sender mostly idle, no idling again, sender idle a third.
      idle_pct = '{0, 77, 0, 33};

      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req         = '0;
      error_count = 0;
      hang_cycles = 0;
      clear_shadow_tables();

      // Fresh cores: undefined codes, preemption toggles and lone-task schedules are no-ops.
      add_row(CMD_UNDEF_LO, 2'd0, 1, 1'b1, make_rsp(0, 0, 0, 0, 0, 1));
      add_row(CMD_UNDEF_HI, 2'd3, 1, 1'b1, make_rsp(0, 0, 0, 0, 0, 1));
      add_row(CMD_BLOCK,    2'd1, 1, 1'b1, make_rsp(0, 0, 0, 0, 0, 1));
      add_row(CMD_ALLOW,    2'd1, 1, 1'b1, make_rsp(0, 0, 0, 0, 0, 1));
      add_row(CMD_TICK,     2'd2, 1, 1'b1, make_rsp(0, 0, 0, 0, 0, 1));
      add_row(CMD_YIELD,    2'd2, 1, 1'b1, make_rsp(0, 0, 0, 0, 0, 1));
      // Two forks on core 0, then rotate through the ring with ticks, yields, block and allow.
      add_row(CMD_FORK,     2'd0, 1, 1'b1, make_rsp(0, 0, 0, 0, 1, 2));
      add_row(CMD_FORK,     2'd0, 1, 1'b1, make_rsp(0, 0, 0, 0, 2, 3));
      add_row(CMD_TICK,     2'd0, 2, 1'b0, '0);
      add_row(CMD_BLOCK,    2'd0, 1, 1'b0, '0);
      add_row(CMD_TICK,     2'd0, 1, 1'b0, '0);
      add_row(CMD_ALLOW,    2'd0, 1, 1'b0, '0);
      add_row(CMD_YIELD,    2'd0, 1, 1'b0, '0);
      // Exit main (slot 0), then fork; the scan starts above main, so the zombie slot stays unused.
      add_row(CMD_EXIT,     2'd0, 1, 1'b0, '0);
      add_row(CMD_FORK,     2'd0, 1, 1'b0, '0);
      // Fill core 3 up to the last slot, then get refused on a full table.
      add_row(CMD_FORK,     2'd3, 14, 1'b0, '0);
      add_row(CMD_FORK,     2'd3, 1, 1'b1, make_rsp(0, 0, 0, 0, 15, 16));
      add_row(CMD_FORK,     2'd3, 1, 1'b1, make_rsp(1, 0, 0, 0, 0, 16));
      add_row(CMD_YIELD,    2'd3, 2, 1'b0, '0);
      // Core 1: last task exits, count saturates at zero, fork revives the core.
      add_row(CMD_EXIT,     2'd1, 1, 1'b1, make_rsp(0, 0, 0, 0, 0, 0));
      add_row(CMD_EXIT,     2'd1, 1, 1'b1, make_rsp(0, 0, 0, 0, 0, 0));
      add_row(CMD_FORK,     2'd1, 1, 1'b1, make_rsp(0, 1, 0, 1, 1, 1));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table back to back.
      foreach (script_rows[i]) begin
         repeat (script_rows[i].reps)
            issue_event(script_rows[i].cmd, script_rows[i].core, script_rows[i].typed,
                        script_rows[i].typed_rsp);
      end

      // Random traffic: stay on one core most of the time so its ring gets deep,
      // switch focus now and then, and sprinkle events for other cores.
      focus_core = $urandom_range(CORE_COUNT - 1);
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         for (int n = 0; n < RANDOM_EVENTS / PHASE_COUNT; n++) begin
            if ($urandom_range(29) == 0)
               focus_core = $urandom_range(CORE_COUNT - 1);
            if ($urandom_range(3) != 0)
               core = 2'(focus_core);
            else
               core = 2'($urandom_range(3));
            sender_pause(idle_pct[ph]);
            issue_event(pick_command(), core, 1'b0, '0);
         end
      end

      // Release start and drain the remaining results.
      start <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
